// File: hdl/tsp_pkg.sv
package tsp_pkg;

    // Field widths of the request and result channels.
    localparam int MODE_W       = 2;
    localparam int SLOT_W       = 4;
    localparam int FREQ_W       = 16;
    localparam int TICKS_W      = 16;
    localparam int PERIOD_W     = 32;
    localparam int COMPARE_W    = 31;
    localparam int PSTATE_W     = 2;
    localparam int POS_W        = 5;

    // Configuration port.
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int SEQLEN_W     = 5;
    localparam int PRESC_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEQ_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESCALER  = 2'd2;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    // Default table depth.
    localparam int MAX_NOTES_DEF = 16;

    // Period divider: 240 MHz timer clock divided by freq * (prescaler + 1).
    localparam int DIVIDEND_W = 28;
    localparam logic [DIVIDEND_W-1:0] TONE_REF_HZ = 28'd240000000;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIVISOR_W  = FREQ_W + PRESC_W + 1;
    localparam int REM_W      = DIVISOR_W + 1;
    localparam int STEP_W     = 5;

    // Player state as reported on the result channel.
    typedef enum logic [PSTATE_W-1:0] {
        PS_IDLE = 2'd0,
        PS_PLAY = 2'd1,
        PS_STOP = 2'd2
    } play_state_t;

    // Sequencer states of the controller.
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_LOOK,
        CS_DIV,
        CS_FIN
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic emit;
    } tsp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic out_free;
    } tsp_sts_t;

endpackage

// File: hdl/tsp_in_if.sv
interface tsp_in_if;
    logic                             valid;
    logic                             ready;
    logic [tsp_pkg::MODE_W-1:0]       mode;
    logic [tsp_pkg::SLOT_W-1:0]       note_slot;
    logic [tsp_pkg::FREQ_W-1:0]       note_freq;
    logic [tsp_pkg::TICKS_W-1:0]      note_ticks;

    modport source (output valid, mode, note_slot, note_freq, note_ticks, input ready);
    modport sink   (input valid, mode, note_slot, note_freq, note_ticks, output ready);
endinterface

// File: hdl/tsp_out_if.sv
interface tsp_out_if;
    logic                             valid;
    logic                             ready;
    logic                             period_write;
    logic [tsp_pkg::PERIOD_W-1:0]     period_value;
    logic                             compare_write;
    logic [tsp_pkg::COMPARE_W-1:0]    compare_value;
    logic [tsp_pkg::PSTATE_W-1:0]     play_state;
    logic [tsp_pkg::POS_W-1:0]        note_position;

    modport source (output valid, period_write, period_value, compare_write,
                    compare_value, play_state, note_position, input ready);
    modport sink   (input valid, period_write, period_value, compare_write,
                    compare_value, play_state, note_position, output ready);
endinterface

// File: hdl/tsp_cfg_if.sv
interface tsp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tsp_pkg::CFG_INDEX_W-1:0]    index;
    logic [tsp_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/tsp_ram.sv
module tsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/tsp_ctrl.sv
module tsp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tsp_pkg::tsp_sts_t sts,
    output tsp_pkg::tsp_cmd_t cmd
);

    tsp_pkg::ctl_state_t              cs_reg, cs_next;
    logic [tsp_pkg::STEP_W-1:0]       cnt_reg, cnt_next;

    // State and divide-step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg  <= tsp_pkg::CS_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            cs_reg  <= cs_next;
            cnt_reg <= cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        cs_next = cs_reg;
        case (cs_reg)
            tsp_pkg::CS_IDLE:
            begin
                if (in_valid)
                begin
                    cs_next = tsp_pkg::CS_LOOK;
                end
            end
            tsp_pkg::CS_LOOK:
            begin
                cs_next = sts.need_div ? tsp_pkg::CS_DIV : tsp_pkg::CS_FIN;
            end
            tsp_pkg::CS_DIV:
            begin
                if (cnt_reg == tsp_pkg::STEP_W'(tsp_pkg::DIV_STEPS - 1))
                begin
                    cs_next = tsp_pkg::CS_FIN;
                end
            end
            tsp_pkg::CS_FIN:
            begin
                if (sts.out_free)
                begin
                    cs_next = tsp_pkg::CS_IDLE;
                end
            end
            default:
            begin
                cs_next = tsp_pkg::CS_IDLE;
            end
        endcase
    end

    // Divide-step counter: cleared on lookup, counts during the divide.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cs_reg == tsp_pkg::CS_LOOK)
        begin
            cnt_next = '0;
        end
        else if (cs_reg == tsp_pkg::CS_DIV)
        begin
            cnt_next = cnt_reg + tsp_pkg::STEP_W'(1);
        end
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (cs_reg)
            tsp_pkg::CS_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            tsp_pkg::CS_LOOK:
            begin
                cmd.update = 1'b1;
            end
            tsp_pkg::CS_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            tsp_pkg::CS_FIN:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A captured request always goes to the table lookup next.
    a_capture_look: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cs_reg == tsp_pkg::CS_LOOK)
        else $error("captured request did not proceed to lookup");

    // The divide never runs past its step count.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cs_reg == tsp_pkg::CS_DIV |-> cnt_reg < tsp_pkg::STEP_W'(tsp_pkg::DIV_STEPS))
        else $error("divide step counter out of range");

endmodule

// File: hdl/tsp_dp.sv
module tsp_dp #(
    parameter int MAX_NOTES = tsp_pkg::MAX_NOTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request payload
    input  logic [tsp_pkg::MODE_W-1:0]        in_mode,
    input  logic [tsp_pkg::SLOT_W-1:0]        in_note_slot,
    input  logic [tsp_pkg::FREQ_W-1:0]        in_note_freq,
    input  logic [tsp_pkg::TICKS_W-1:0]       in_note_ticks,
    // Configuration writes
    input  logic                              cfg_we,
    input  logic [tsp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tsp_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_period_write,
    output logic [tsp_pkg::PERIOD_W-1:0]      out_period_value,
    output logic                              out_compare_write,
    output logic [tsp_pkg::COMPARE_W-1:0]     out_compare_value,
    output logic [tsp_pkg::PSTATE_W-1:0]      out_play_state,
    output logic [tsp_pkg::POS_W-1:0]         out_note_position,
    // Controller handshake
    input  tsp_pkg::tsp_cmd_t                 cmd,
    output tsp_pkg::tsp_sts_t                 sts
);

    localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int ENTRY_W = tsp_pkg::FREQ_W + tsp_pkg::TICKS_W;
    localparam logic [tsp_pkg::POS_W-1:0] LEN_CAP =
        tsp_pkg::POS_W'((MAX_NOTES > 31) ? 31 : MAX_NOTES);

    // Captured request.
    logic [tsp_pkg::MODE_W-1:0]     mode_reg;
    logic [tsp_pkg::SLOT_W-1:0]     slot_reg;
    logic [tsp_pkg::FREQ_W-1:0]     freq_in_reg;
    logic [tsp_pkg::TICKS_W-1:0]    ticks_in_reg;

    // Configuration registers.
    logic [tsp_pkg::SEQLEN_W-1:0]   seqlen_reg;
    logic                           rep_reg;
    logic [tsp_pkg::PRESC_W-1:0]    presc_reg;

    // Player state.
    tsp_pkg::play_state_t           pstate_reg, pstate_next;
    logic [tsp_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [tsp_pkg::TICKS_W-1:0]    el_reg, el_next;
    logic                           tone_reg, tone_next;
    logic                           cmpw_reg, cmpw_next;

    // Divider.
    logic [tsp_pkg::DIVISOR_W-1:0]  divisor_reg;
    logic [tsp_pkg::REM_W-1:0]      rem_reg;
    logic [tsp_pkg::DIVIDEND_W-1:0] quo_reg;

    // Result register.
    logic                           ov_reg;
    logic                           o_pw_reg;
    logic [tsp_pkg::PERIOD_W-1:0]   o_pv_reg;
    logic                           o_cw_reg;
    logic [tsp_pkg::COMPARE_W-1:0]  o_cv_reg;
    logic [tsp_pkg::PSTATE_W-1:0]   o_ps_reg;
    logic [tsp_pkg::POS_W-1:0]      o_np_reg;

    logic [ENTRY_W-1:0]             rd_entry;
    logic [tsp_pkg::FREQ_W-1:0]     tbl_freq;
    logic [tsp_pkg::TICKS_W-1:0]    tbl_dur;
    logic                           tbl_we;
    logic [tsp_pkg::POS_W-1:0]      len;
    logic [tsp_pkg::TICKS_W-1:0]    el_inc;
    logic [tsp_pkg::PRESC_W:0]      presc_p1;
    logic [tsp_pkg::DIVISOR_W-1:0]  product;
    logic [tsp_pkg::REM_W-1:0]      rem_sh;
    logic                           rem_ge;
    logic [tsp_pkg::PERIOD_W-1:0]   period;

    // Note table: frequency in the upper half, duration in the lower half.
    assign tbl_we = cmd.update && (mode_reg == tsp_pkg::MODE_LOAD) &&
                    (int'(slot_reg) < MAX_NOTES);

    tsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NOTES)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (AW'(slot_reg)),
        .wdata ({freq_in_reg, ticks_in_reg}),
        .re    (cmd.capture),
        .raddr (AW'(pos_reg)),
        .rdata (rd_entry)
    );

    assign tbl_freq = rd_entry[ENTRY_W-1:tsp_pkg::TICKS_W];
    assign tbl_dur  = rd_entry[tsp_pkg::TICKS_W-1:0];

    // Effective sequence length, capped at the table depth.
    assign len = (seqlen_reg > LEN_CAP) ? LEN_CAP : seqlen_reg;

    // Player update for the captured request.
    always_comb
    begin
        pstate_next = pstate_reg;
        pos_next    = pos_reg;
        el_next     = el_reg;
        tone_next   = 1'b0;
        cmpw_next   = 1'b0;
        el_inc      = el_reg + tsp_pkg::TICKS_W'(1);
        case (mode_reg)
            tsp_pkg::MODE_RESTART:
            begin
                pstate_next = tsp_pkg::PS_IDLE;
            end
            tsp_pkg::MODE_TICK:
            begin
                case (pstate_reg)
                    tsp_pkg::PS_IDLE:
                    begin
                        pos_next    = '0;
                        el_next     = '0;
                        pstate_next = tsp_pkg::PS_PLAY;
                    end
                    tsp_pkg::PS_PLAY:
                    begin
                        cmpw_next = 1'b1;
                        if (pos_reg < len)
                        begin
                            tone_next = (tbl_freq != '0);
                            if (el_inc >= tbl_dur)
                            begin
                                pos_next = pos_reg + tsp_pkg::POS_W'(1);
                                el_next  = '0;
                            end
                            else
                            begin
                                el_next = el_inc;
                            end
                        end
                        if (pos_next >= len)
                        begin
                            if (rep_reg || (pos_next != len))
                            begin
                                pstate_next = tsp_pkg::PS_IDLE;
                            end
                            else
                            begin
                                pstate_next = tsp_pkg::PS_STOP;
                            end
                        end
                    end
                    tsp_pkg::PS_STOP:
                    begin
                        cmpw_next = 1'b1;
                        if (pos_reg != len)
                        begin
                            pstate_next = tsp_pkg::PS_IDLE;
                        end
                    end
                    default:
                    begin
                        pstate_next = pstate_reg;
                    end
                endcase
            end
            default:
            begin
                pstate_next = pstate_reg;
            end
        endcase
    end

    // Divisor freq * (prescaler + 1); one restoring step per cycle.
    assign presc_p1 = {1'b0, presc_reg} + (tsp_pkg::PRESC_W+1)'(1);
    assign product  = tsp_pkg::DIVISOR_W'(tbl_freq) * tsp_pkg::DIVISOR_W'(presc_p1);
    assign rem_sh   = {rem_reg[tsp_pkg::REM_W-2:0], quo_reg[tsp_pkg::DIVIDEND_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, divisor_reg};

    // Period is quotient minus one, wrapping when the quotient is zero.
    assign period = tsp_pkg::PERIOD_W'(quo_reg) - tsp_pkg::PERIOD_W'(1);

    assign sts.need_div = tone_next;
    assign sts.out_free = !ov_reg || out_ready;

    // Control state: player, configuration and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pstate_reg <= tsp_pkg::PS_IDLE;
            pos_reg    <= '0;
            el_reg     <= '0;
            seqlen_reg <= '0;
            rep_reg    <= 1'b0;
            presc_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                pstate_reg <= pstate_next;
                pos_reg    <= pos_next;
                el_reg     <= el_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    tsp_pkg::CFG_SEQ_LENGTH: seqlen_reg <= cfg_data[tsp_pkg::SEQLEN_W-1:0];
                    tsp_pkg::CFG_REPEAT:     rep_reg    <= cfg_data[0];
                    tsp_pkg::CFG_PRESCALER:  presc_reg  <= cfg_data[tsp_pkg::PRESC_W-1:0];
                    default:                 rep_reg    <= rep_reg;
                endcase
            end
            if (cmd.emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg     <= in_mode;
            slot_reg     <= in_note_slot;
            freq_in_reg  <= in_note_freq;
            ticks_in_reg <= in_note_ticks;
        end
        if (cmd.update)
        begin
            tone_reg    <= tone_next;
            cmpw_reg    <= cmpw_next;
            divisor_reg <= product;
            rem_reg     <= '0;
            quo_reg     <= tsp_pkg::TONE_REF_HZ;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? (rem_sh - {1'b0, divisor_reg}) : rem_sh;
            quo_reg <= {quo_reg[tsp_pkg::DIVIDEND_W-2:0], rem_ge};
        end
        if (cmd.emit)
        begin
            o_pw_reg <= tone_reg;
            o_pv_reg <= tone_reg ? period : '0;
            o_cw_reg <= cmpw_reg;
            o_cv_reg <= tone_reg ? period[tsp_pkg::PERIOD_W-1:1] : '0;
            o_ps_reg <= pstate_reg;
            o_np_reg <= pos_reg;
        end
    end

    assign out_valid         = ov_reg;
    assign out_period_write  = o_pw_reg;
    assign out_period_value  = o_pv_reg;
    assign out_compare_write = o_cw_reg;
    assign out_compare_value = o_cv_reg;
    assign out_play_state    = o_ps_reg;
    assign out_note_position = o_np_reg;

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!ov_reg || out_ready))
        else $error("result register overwritten");

    // The divider only runs on a nonzero divisor.
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> divisor_reg != '0)
        else $error("divide started with zero divisor");

    // A period write always comes with a compare write.
    a_period_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && o_pw_reg) |-> o_cw_reg)
        else $error("period written without compare");

endmodule

// File: hdl/tone_sequence_player_unit.sv
// Tone sequence player. Requests arrive on in_ch: a load request writes one
// note (frequency, duration) into the note table, a restart request forces
// the player idle, and a tick request advances the player and may drive a
// new timer period and compare. Every request gives exactly one result on
// out_ch with the write flags, values, player state and note position.
// Configuration (sequence length, repeat, prescaler) is written on cfg,
// which is always ready; write it only while no request is in flight.
// A tick that plays a tone passes through lookup, product, a 28-step
// restoring divide of 240 MHz by freq * (prescaler + 1) and finish; every
// other request goes from lookup straight to finish.
// One request is in flight at a time, so the block takes no new request
// until the last one's result is loaded into the output register.
// A finished result waits in the output register; a stalled receiver only
// holds the block once the next result is done and cannot be loaded.
// Reset clears the player to idle, position and elapsed count to zero and
// all configuration to zero. The note table is not cleared.
module tone_sequence_player_unit #(
    parameter int MAX_NOTES = tsp_pkg::MAX_NOTES_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    tsp_in_if.sink    in_ch,
    tsp_out_if.source out_ch,
    tsp_cfg_if.sink   cfg
);

    tsp_pkg::tsp_cmd_t cmd;
    tsp_pkg::tsp_sts_t sts;
    logic              in_ready;

    assign in_ch.ready = in_ready;
    assign cfg.ready   = 1'b1;

    // Sequencer.
    tsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Player state, note table, divider and result register.
    tsp_dp #(
        .MAX_NOTES (MAX_NOTES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_mode           (in_ch.mode),
        .in_note_slot      (in_ch.note_slot),
        .in_note_freq      (in_ch.note_freq),
        .in_note_ticks     (in_ch.note_ticks),
        .cfg_we            (cfg.valid),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .out_valid         (out_ch.valid),
        .out_ready         (out_ch.ready),
        .out_period_write  (out_ch.period_write),
        .out_period_value  (out_ch.period_value),
        .out_compare_write (out_ch.compare_write),
        .out_compare_value (out_ch.compare_value),
        .out_play_state    (out_ch.play_state),
        .out_note_position (out_ch.note_position),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tsp_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int NOTES       = MAX_NOTES_DEF;
    localparam int SETTLE_CYC  = 40;
    localparam int HOLD_CYC    = 400;
    localparam int STALL_LIMIT = 5000;

    // Mode code that the block must ignore.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [31:0]       TIMER_HZ    = 32'd240000000;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SLOT_W-1:0]  slot;
        logic [FREQ_W-1:0]  freq;
        logic [TICKS_W-1:0] ticks;
    } note_req_t;

    typedef struct packed {
        logic                 pwr;
        logic [PERIOD_W-1:0]  period;
        logic                 cwr;
        logic [COMPARE_W-1:0] compare;
        play_state_t          state;
        logic [POS_W-1:0]     pos;
    } tone_res_t;

    logic clk;
    logic rst_n;

    tsp_in_if  req_if ();
    tsp_out_if rsp_if ();
    tsp_cfg_if cfg_if ();

    tone_sequence_player_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_if),
        .out_ch (rsp_if),
        .cfg    (cfg_if)
    );

    // Shadow copy of the configuration and of the player.
    logic [SEQLEN_W-1:0] seq_len_sh;
    logic                repeat_sh;
    logic [PRESC_W-1:0]  presc_sh;
    play_state_t         plr_state;
    logic [POS_W-1:0]    plr_pos;
    logic [TICKS_W-1:0]  plr_elapsed;
    logic [FREQ_W-1:0]   freq_tab [NOTES];
    logic [TICKS_W-1:0]  dur_tab [NOTES];

    note_req_t pending_q [$];
    tone_res_t tone_q [$];

    int n_queued       = 0;
    int n_checked      = 0;
    int err_cnt        = 0;
    int n_tones        = 0;
    int n_silent       = 0;
    int n_cfg          = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int quiet_cnt      = 0;
    bit hold_arm       = 1'b0;
    bit hold_done      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Timer writes for one note: a tone sets period and compare, silence
    // sets only the compare to zero.
    function automatic void tone_out(input logic [FREQ_W-1:0] freq, inout tone_res_t res);
        logic [31:0] quot;
        logic [31:0] per;
        if (freq == '0)
        begin
            res.cwr     = 1'b1;
            res.compare = '0;
        end
        else
        begin
            quot        = (TIMER_HZ / {16'd0, freq}) / ({16'd0, presc_sh} + 32'd1);
            per         = quot - 32'd1;
            res.pwr     = 1'b1;
            res.period  = per;
            res.cwr     = 1'b1;
            res.compare = per[31:1];
        end
    endfunction

    // Advances the shadow player by one request and returns its result.
    function automatic tone_res_t sequencer_step(input note_req_t r);
        tone_res_t        res;
        logic [POS_W-1:0] len;
        res = '0;
        len = (seq_len_sh > NOTES) ? POS_W'(NOTES) : seq_len_sh;
        case (r.mode)
            MODE_LOAD:
            begin
                freq_tab[r.slot] = r.freq;
                dur_tab[r.slot]  = r.ticks;
            end
            MODE_RESTART:
                plr_state = PS_IDLE;
            MODE_TICK:
            begin
                if (plr_state == PS_IDLE)
                begin
                    plr_pos     = '0;
                    plr_elapsed = '0;
                    plr_state   = PS_PLAY;
                end
                else if (plr_state == PS_PLAY)
                begin
                    if (plr_pos < len)
                    begin
                        plr_elapsed = plr_elapsed + 1'b1;
                        tone_out(freq_tab[plr_pos[SLOT_W-1:0]], res);
                        if (plr_elapsed >= dur_tab[plr_pos[SLOT_W-1:0]])
                        begin
                            plr_pos     = plr_pos + 1'b1;
                            plr_elapsed = '0;
                        end
                    end
                    else
                        tone_out('0, res);
                    // Past the end: loop, or stop only when exactly at the end.
                    if (plr_pos >= len)
                    begin
                        if (repeat_sh || plr_pos != len)
                            plr_state = PS_IDLE;
                        else
                            plr_state = PS_STOP;
                    end
                end
                else
                begin
                    if (plr_pos != len)
                        plr_state = PS_IDLE;
                    tone_out('0, res);
                end
            end
            default: ;
        endcase
        res.state = plr_state;
        res.pos   = plr_pos;
        return res;
    endfunction

    function automatic bit field_bad(input string name, input logic [31:0] exp_v,
                                     input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Request driver: predicts each accepted request and offers the next one.
    always @(posedge clk)
    begin : req_drv
        note_req_t cur;
        note_req_t nxt;
        if (!rst_n)
            req_if.valid <= 1'b0;
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                cur.mode  = req_if.mode;
                cur.slot  = req_if.note_slot;
                cur.freq  = req_if.note_freq;
                cur.ticks = req_if.note_ticks;
                tone_q.push_back(sequencer_step(cur));
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_q.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.mode       <= nxt.mode;
                    req_if.note_slot  <= nxt.slot;
                    req_if.note_freq  <= nxt.freq;
                    req_if.note_ticks <= nxt.ticks;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each result with the oldest prediction.
    always @(posedge clk)
    begin : rsp_mon
        tone_res_t want;
        bit        bad;
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                n_checked++;
                if (tone_q.size() == 0)
                begin
                    $display("%0t: result with no request pending, state %0d position %0d",
                             $time, rsp_if.play_state, rsp_if.note_position);
                    err_cnt++;
                end
                else
                begin
                    want = tone_q.pop_front();
                    bad  = 1'b0;
                    bad |= field_bad("period_write", want.pwr, rsp_if.period_write);
                    bad |= field_bad("period_value", want.period, rsp_if.period_value);
                    bad |= field_bad("compare_write", want.cwr, rsp_if.compare_write);
                    bad |= field_bad("compare_value", want.compare, rsp_if.compare_value);
                    bad |= field_bad("play_state", want.state, rsp_if.play_state);
                    bad |= field_bad("note_position", want.pos, rsp_if.note_position);
                    if (bad)
                        err_cnt++;
                    if (want.pwr)
                        n_tones++;
                    else if (want.cwr)
                        n_silent++;
                end
            end
            rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, started once from the stimulus.
    always @(posedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYC;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cnt <= 0;
            else
                quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt >= STALL_LIMIT)
            begin
                $display("tb_top: no handshake for %0d cycles", quiet_cnt);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    task automatic push_req(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s,
                            input logic [FREQ_W-1:0] f, input logic [TICKS_W-1:0] t);
        note_req_t r;
        r.mode  = m;
        r.slot  = s;
        r.freq  = f;
        r.ticks = t;
        pending_q.push_back(r);
        n_queued++;
    endtask

    // Waits until every request has its result, then lets the block settle.
    task automatic wait_drained();
        while (n_checked != n_queued)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Called at a rising edge; returns at the edge that took the write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            CFG_SEQ_LENGTH: seq_len_sh = val[SEQLEN_W-1:0];
            CFG_REPEAT:     repeat_sh  = val[0];
            CFG_PRESCALER:  presc_sh   = val[PRESC_W-1:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic set_config(input int len, input int rep, input int presc);
        write_reg(CFG_SEQ_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_REPEAT, CFG_DATA_W'(rep));
        write_reg(CFG_PRESCALER, CFG_DATA_W'(presc));
        cfg_if.valid <= 1'b0;
    endtask

    // One random phase: a fresh song in all slots, then a random mix that
    // is mostly ticks so the player walks through the sequence.
    task automatic run_phase(input int len, input int rep, input int presc, input int s_idle,
                             input int r_stall, input int n, input bit pressure);
        int                 sel;
        logic [FREQ_W-1:0]  f;
        logic [TICKS_W-1:0] t;
        logic [MODE_W-1:0]  m;
        wait_drained();
        set_config(len, rep, presc);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        if (pressure)
            hold_arm = 1'b1;
        for (int s = 0; s < NOTES; s++)
            push_req(MODE_LOAD, SLOT_W'(s), FREQ_W'($urandom_range(65535)),
                     TICKS_W'($urandom_range(3)));
        for (int i = NOTES; i < n; i++)
        begin
            sel = $urandom_range(99);
            f   = ($urandom_range(7) == 0) ? '0 : FREQ_W'($urandom_range(65535));
            t   = ($urandom_range(29) == 0) ? TICKS_W'($urandom_range(65535))
                                            : TICKS_W'($urandom_range(4));
            if (sel < 60)
                m = MODE_TICK;
            else if (sel < 85)
                m = MODE_LOAD;
            else if (sel < 95)
                m = MODE_RESTART;
            else
                m = MODE_UNUSED;
            push_req(m, SLOT_W'($urandom_range(15)), f, t);
        end
    endtask

    initial
    begin : stim
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.mode       = MODE_TICK;
        req_if.note_slot  = '0;
        req_if.note_freq  = '0;
        req_if.note_ticks = '0;
        rsp_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_SEQ_LENGTH;
        cfg_if.data       = '0;
        seq_len_sh        = '0;
        repeat_sh         = 1'b0;
        presc_sh          = '0;
        plr_state         = PS_IDLE;
        plr_pos           = '0;
        plr_elapsed       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Zero length after reset: silence, then stop; ignored mode; restart.
        push_req(MODE_TICK, 4'h0, 16'h0000, 16'h0000);
        push_req(MODE_TICK, 4'hF, 16'hFFFF, 16'hFFFF);
        push_req(MODE_TICK, 4'h0, 16'h0000, 16'h0000);
        push_req(MODE_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF);
        push_req(MODE_RESTART, 4'hF, 16'hFFFF, 16'hFFFF);
        push_req(MODE_TICK, 4'h0, 16'h0000, 16'h0000);
        // Fill the whole table, field extremes at the ends.
        push_req(MODE_LOAD, 4'h0, 16'hFFFF, 16'h0000);
        push_req(MODE_LOAD, 4'h1, 16'h0001, 16'h0001);
        push_req(MODE_LOAD, 4'h2, 16'h0000, 16'h0002);
        for (int s = 3; s < NOTES - 1; s++)
            push_req(MODE_LOAD, SLOT_W'(s), FREQ_W'($urandom_range(1, 65535)),
                     TICKS_W'($urandom_range(3)));
        push_req(MODE_LOAD, 4'hF, 16'h0000, 16'hFFFF);

        // Largest prescaler: the fastest note's divide gives a zero quotient.
        // Plays to the end without repeat and stops.
        wait_drained();
        set_config(2, 0, 65535);
        repeat (3) push_req(MODE_TICK, 4'h0, 16'h0000, 16'h0000);

        // Length beyond the table while stopped sends the player idle.
        wait_drained();
        set_config(31, 1, 0);
        repeat (3) push_req(MODE_TICK, 4'h0, 16'h0000, 16'h0000);
        push_req(MODE_RESTART, 4'h0, 16'h0000, 16'h0000);

        run_phase(4, 1, 0, 0, 0, 130, 1'b0);
        run_phase(16, 1, 65535, 68, 0, 130, 1'b0);
        run_phase(31, 0, 3, 0, 68, 130, 1'b0);
        run_phase(0, 1, 1000, 24, 24, 100, 1'b0);
        run_phase(7, 0, $urandom_range(65535), 0, 0, 130, 1'b1);
        run_phase(16, 0, 0, 68, 0, 130, 1'b0);
        run_phase(3, 1, 65535, 0, 68, 130, 1'b0);
        run_phase(12, 1, $urandom_range(65535), 24, 24, 140, 1'b0);

        wait_drained();
        if (tone_q.size() != 0)
        begin
            $display("%0t: %0d predicted results never arrived", $time, tone_q.size());
            err_cnt++;
        end
        $display("tb_top: %0d requests checked, %0d tone writes, %0d silence writes",
                 n_checked, n_tones, n_silent);
        $display("tb_top: %0d register writes, idle and stall mixes, one %0d-cycle hold-off",
                 n_cfg, HOLD_CYC);
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: sim.f
hdl/tsp_pkg.sv
hdl/tsp_in_if.sv
hdl/tsp_out_if.sv
hdl/tsp_cfg_if.sv
hdl/tsp_ram.sv
hdl/tsp_ctrl.sv
hdl/tsp_dp.sv
hdl/tone_sequence_player_unit.sv
sim/tb_top.sv
